[rtl/core/mivg_pkg.sv]
// ============================================================================
// mivg_pkg
// Shared types, codes and helper functions of the inverted-V gesture detector
// ============================================================================
`default_nettype none

package mivg_pkg;

    localparam int BUTTON_W  = 3;
    localparam int MOVE_W    = 9;
    localparam int TRAVEL_W  = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam int BTN_LEFT   = 0;
    localparam int BTN_MIDDLE = 1;
    localparam int BTN_RIGHT  = 2;

    typedef enum logic [2:0] {
        EV_MOVE          = 3'd0,
        EV_LEFT_PRESS    = 3'd1,
        EV_LEFT_RELEASE  = 3'd2,
        EV_RIGHT_PRESS   = 3'd3,
        EV_RIGHT_RELEASE = 3'd4,
        EV_OTHER         = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_UP       = 3'd1,
        PH_VERTEX   = 3'd2,
        PH_DOWN     = 3'd3,
        PH_FINISHED = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH = 1'b0,
        CFG_TOLERANCE  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BUTTON_W-1:0]      buttons;
        logic signed [MOVE_W-1:0] dx;
        logic signed [MOVE_W-1:0] dy;
    } pkt_t;

    typedef struct packed {
        event_t kind;
        phase_t phase;
        logic   done;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_length;
        logic [CFG_W-1:0] tolerance;
    } cfg_t;

    // travel magnitude on either axis beyond tolerance
    function automatic logic strayed(logic [TRAVEL_W-1:0] tx, logic [TRAVEL_W-1:0] ty,
                                     logic [CFG_W-1:0] tol);
        logic signed [TRAVEL_W:0] sx;
        logic signed [TRAVEL_W:0] sy;
        logic signed [TRAVEL_W:0] lim;
        sx  = $signed({tx[TRAVEL_W-1], tx});
        sy  = $signed({ty[TRAVEL_W-1], ty});
        lim = $signed({{(TRAVEL_W+1-CFG_W){1'b0}}, tol});
        return (sx > lim) || (sx < -lim) || (sy > lim) || (sy < -lim);
    endfunction

    function automatic logic [TRAVEL_W-1:0] ext_move(logic signed [MOVE_W-1:0] d);
        return {{(TRAVEL_W-MOVE_W){d[MOVE_W-1]}}, d};
    endfunction

endpackage

`default_nettype wire

[rtl/core/mivg_if.sv]
// ============================================================================
// mivg_if
// Valid/ready channels for mouse packets and gesture results
// ============================================================================
`default_nettype none

interface mivg_in_if;
    logic              valid;
    logic              ready;
    logic              left_button;
    logic              middle_button;
    logic              right_button;
    logic              x_overflow;
    logic              y_overflow;
    logic signed [8:0] move_x;
    logic signed [8:0] move_y;

    modport source (output valid, left_button, middle_button, right_button,
                    x_overflow, y_overflow, move_x, move_y, input ready);
    modport sink   (input valid, left_button, middle_button, right_button,
                    x_overflow, y_overflow, move_x, move_y, output ready);
endinterface

interface mivg_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [2:0] gesture_phase;
    logic       gesture_done;

    modport source (output valid, event_kind, gesture_phase, gesture_done, input ready);
    modport sink   (input valid, event_kind, gesture_phase, gesture_done, output ready);
endinterface

`default_nettype wire

[rtl/core/mivg_classify.sv]
// ============================================================================
// mivg_classify
// Button history and press/release/other classification of each packet
// ============================================================================
`default_nettype none

module mivg_classify
    import mivg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [BUTTON_W-1:0] buttons,
    output event_t                   kind
);

    logic [BUTTON_W-1:0] prev_reg;
    logic [BUTTON_W-1:0] prev_next;

    logic [BUTTON_W-1:0] only_left;
    logic [BUTTON_W-1:0] only_right;
    logic                cur_both;
    logic                prev_both;

    assign only_left  = BUTTON_W'(1) << BTN_LEFT;
    assign only_right = BUTTON_W'(1) << BTN_RIGHT;
    assign cur_both   = buttons[BTN_LEFT] & buttons[BTN_RIGHT];
    assign prev_both  = prev_reg[BTN_LEFT] & prev_reg[BTN_RIGHT];

    always_comb
    begin
        kind = EV_MOVE;
        if (prev_reg == '0)
        begin
            if (buttons == only_right)
                kind = EV_RIGHT_PRESS;
            else if (buttons == only_left)
                kind = EV_LEFT_PRESS;
        end
        else if (buttons == '0)
        begin
            if (prev_reg == only_right)
                kind = EV_RIGHT_RELEASE;
            else if (prev_reg == only_left)
                kind = EV_LEFT_RELEASE;
        end
        else if (buttons[BTN_MIDDLE] || prev_reg[BTN_MIDDLE] || cur_both || prev_both)
        begin
            kind = EV_OTHER;
        end
    end

    assign prev_next = step ? buttons : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else
            prev_reg <= prev_next;
    end

endmodule

`default_nettype wire

[rtl/core/mivg_gesture.sv]
// ============================================================================
// mivg_gesture
// Inverted-V gesture state machine with wrapping travel accumulators
// ============================================================================
`default_nettype none

module mivg_gesture
    import mivg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire event_t                   kind,
    input  wire logic signed [MOVE_W-1:0] dx,
    input  wire logic signed [MOVE_W-1:0] dy,
    input  wire cfg_t                     cfg,
    output phase_t                        phase
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [TRAVEL_W-1:0] tx_reg;
    logic [TRAVEL_W-1:0] tx_next;
    logic [TRAVEL_W-1:0] ty_reg;
    logic [TRAVEL_W-1:0] ty_next;

    logic [TRAVEL_W-1:0]      tx_add;
    logic [TRAVEL_W-1:0]      ty_add;
    logic                     dx_neg;
    logic                     dy_neg;
    logic                     dy_pos;
    logic signed [MOVE_W:0]   tol_s;
    logic signed [MOVE_W:0]   dx_s;
    logic signed [MOVE_W:0]   dy_s;
    logic                     dx_back_ok;
    logic                     dy_down_ok;
    logic                     dy_up_ok;
    logic                     steep_up;
    logic                     steep_down;
    logic                     long_enough;
    logic                     strayed_now;
    logic                     strayed_vertex;

    assign tx_add = tx_reg + ext_move(dx);
    assign ty_add = ty_reg + ext_move(dy);

    assign dx_neg = dx[MOVE_W-1];
    assign dy_neg = dy[MOVE_W-1];
    assign dy_pos = !dy_neg && (dy != '0);

    assign tol_s = $signed({{(MOVE_W+1-CFG_W){1'b0}}, cfg.tolerance});
    assign dx_s  = $signed({dx[MOVE_W-1], dx});
    assign dy_s  = $signed({dy[MOVE_W-1], dy});

    // stray against the leg direction stays strictly under tolerance
    assign dx_back_ok = dx_neg && ((tol_s + dx_s) > 0);
    assign dy_down_ok = dy_neg && ((tol_s + dy_s) > 0);
    assign dy_up_ok   = dy_pos && (dy_s < tol_s);

    assign steep_up    = dy > dx;
    assign steep_down  = (dx_s + dy_s) < 0;
    assign long_enough = $signed({tx_reg[TRAVEL_W-1], tx_reg})
                         >= $signed({{(TRAVEL_W+1-CFG_W){1'b0}}, cfg.min_length});

    assign strayed_now    = strayed(tx_reg, ty_reg, cfg.tolerance);
    assign strayed_vertex = strayed(tx_add, ty_add, cfg.tolerance);

    always_comb
    begin
        phase_next = phase_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        case (phase_reg)
            PH_START:
            begin
                if (kind == EV_LEFT_PRESS)
                begin
                    tx_next    = '0;
                    phase_next = PH_UP;
                end
            end
            PH_UP:
            begin
                if (kind == EV_MOVE)
                begin
                    if (!dx_neg && !dy_neg)
                    begin
                        if (steep_up)
                            tx_next = tx_add;
                        else if (strayed_now)
                            phase_next = PH_START;
                    end
                    else if (dx_back_ok || dy_down_ok)
                        tx_next = tx_add;
                    else
                        phase_next = PH_START;
                end
                else if (kind == EV_LEFT_RELEASE && long_enough)
                begin
                    tx_next    = '0;
                    ty_next    = '0;
                    phase_next = PH_VERTEX;
                end
                else
                    phase_next = PH_START;
            end
            PH_VERTEX:
            begin
                if (kind == EV_MOVE)
                begin
                    tx_next = tx_add;
                    ty_next = ty_add;
                    if (strayed_vertex)
                        phase_next = PH_START;
                end
                else if (kind == EV_RIGHT_PRESS)
                begin
                    tx_next    = '0;
                    phase_next = PH_DOWN;
                end
                else if (kind == EV_LEFT_PRESS)
                begin
                    tx_next    = '0;
                    phase_next = PH_UP;
                end
                else
                    phase_next = PH_START;
            end
            PH_DOWN:
            begin
                if (kind == EV_MOVE)
                begin
                    if (!dx_neg && !dy_pos)
                    begin
                        if (steep_down)
                            tx_next = tx_add;
                        else if (strayed_now)
                            phase_next = PH_START;
                    end
                    else if (dx_back_ok || dy_up_ok)
                        tx_next = tx_add;
                    else
                        phase_next = PH_START;
                end
                else if (kind == EV_RIGHT_RELEASE && long_enough)
                    phase_next = PH_FINISHED;
                else
                    phase_next = PH_START;
            end
            PH_FINISHED:
            begin
                phase_next = PH_FINISHED;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            tx_reg    <= '0;
            ty_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
        end
    end

    assign phase = phase_next;

endmodule

`default_nettype wire

[rtl/core/mouse_inverted_v_gesture_detector_top.sv]
// ============================================================================
// mouse_inverted_v_gesture_detector_top
// Mouse packet classifier and inverted-V gesture detector
// ============================================================================
// Accepts one decoded mouse packet per clock while the result side is not
// stalled and returns one result per packet: the button event kind, the
// gesture phase after the packet and a done flag. The packet is held in the
// input register, and the classify and gesture update then load the result
// register from it. Result back-pressure stalls both registers. The only loop
// is the state update of button history, phase and travel. Write
// min_horizontal_length (index 0) and tolerance (index 1) only while idle.
`default_nettype none

module mouse_inverted_v_gesture_detector_top
    import mivg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mivg_in_if.sink                   packet,
    mivg_out_if.source                result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    pkt_t    pkt_reg;
    pkt_t    pkt_next;
    logic    pkt_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;

    logic    advance;
    logic    step;
    logic    in_take;
    event_t  kind;
    phase_t  phase;

    assign advance      = !res_valid_reg || result.ready;
    assign step         = pkt_valid_reg && advance;
    assign packet.ready = !pkt_valid_reg || advance;
    assign in_take      = packet.valid && packet.ready;

    // overflowed axis counts as no movement
    always_comb
    begin
        pkt_next.buttons[BTN_LEFT]   = packet.left_button;
        pkt_next.buttons[BTN_MIDDLE] = packet.middle_button;
        pkt_next.buttons[BTN_RIGHT]  = packet.right_button;
        pkt_next.dx = packet.x_overflow ? '0 : packet.move_x;
        pkt_next.dy = packet.y_overflow ? '0 : packet.move_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length <= '0;
            cfg_reg.tolerance  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_LENGTH: cfg_reg.min_length <= cfg_data;
                CFG_TOLERANCE:  cfg_reg.tolerance  <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pkt_valid_reg <= 1'b0;
        else if (packet.ready)
            pkt_valid_reg <= packet.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            pkt_reg <= pkt_next;
    end

    mivg_classify u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .buttons (pkt_reg.buttons),
        .kind    (kind)
    );

    mivg_gesture u_gesture (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .kind  (kind),
        .dx    (pkt_reg.dx),
        .dy    (pkt_reg.dy),
        .cfg   (cfg_reg),
        .phase (phase)
    );

    always_comb
    begin
        res_next.kind  = kind;
        res_next.phase = phase;
        res_next.done  = (phase == PH_FINISHED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= pkt_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.event_kind    = res_reg.kind;
    assign result.gesture_phase = res_reg.phase;
    assign result.gesture_done  = res_reg.done;

endmodule

`default_nettype wire
